// ----- sv/sdff_pkg.sv -----
package sdff_pkg;

  localparam int SampleW   = 32;
  localparam int MaxDigits = 10;
  localparam int BcdW      = 4 * MaxDigits;
  localparam int DigIdxW   = 4;
  localparam int CharW     = 8;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;
  localparam int FrameW    = 8;

  // Two magnitude bits are folded into the BCD accumulator per cycle.
  localparam int BitsPerStep = 2;
  localparam int ConvSteps   = SampleW / BitsPerStep;
  localparam int StepW       = 4;

  localparam logic [CharW-1:0] CH_START = 8'h24;  // '$'
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [CharW-1:0] CH_END   = 8'h3B;  // ';'
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;  // '0'

  // Register select taken from the word address bit of paddr.
  localparam logic REG_VALUES_PER_FRAME = 1'b0;

  typedef struct packed {
    logic               start;
    logic               negative;
    logic               closes;
    logic [SampleW-1:0] mag;
  } desc_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  // One shift-and-add-3 step of the binary to BCD conversion.
  function automatic logic [BcdW-1:0] dabble_step(input logic [BcdW-1:0] bcd,
                                                  input logic din);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < MaxDigits; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], din};
  endfunction

  // Position of the most significant nonzero digit, zero when all are zero.
  function automatic logic [DigIdxW-1:0] lead_digit(input logic [BcdW-1:0] bcd);
    logic [DigIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx = DigIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/sdff_front.sv -----
module sdff_front
  import sdff_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [SampleW-1:0]  sample_value,
  output logic                full,
  input  logic                q_full,
  output logic                q_push,
  output desc_t               q_desc,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [FrameW-1:0] values_per_frame_r, values_per_frame_nxt;
  logic [FrameW-1:0] value_index_r, value_index_nxt;
  logic              cfg_wr;
  logic              accept;
  logic              closes;
  logic              negative;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_VALUES_PER_FRAME) ?
                  {{(CfgDataW-FrameW){1'b0}}, values_per_frame_r} : '0;

  assign full   = q_full;
  assign accept = push & ~q_full;

  // A frame length of zero behaves like one.
  assign closes   = ({1'b0, value_index_r} + 9'd1) >= {1'b0, values_per_frame_r};
  assign negative = sample_value[SampleW-1];

  always_comb begin
    q_push          = accept;
    q_desc.start    = (value_index_r == '0);
    q_desc.negative = negative;
    q_desc.closes   = closes;
    q_desc.mag      = negative ? (SampleW'(0) - sample_value) : sample_value;
  end

  always_comb begin
    values_per_frame_nxt = values_per_frame_r;
    if (cfg_wr && (paddr[2] == REG_VALUES_PER_FRAME)) begin
      values_per_frame_nxt = pwdata[FrameW-1:0];
    end
    value_index_nxt = value_index_r;
    if (accept) begin
      value_index_nxt = closes ? '0 : value_index_r + FrameW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      values_per_frame_r <= FrameW'(1);
      value_index_r      <= '0;
    end else begin
      values_per_frame_r <= values_per_frame_nxt;
      value_index_r      <= value_index_nxt;
    end
  end

endmodule

// ----- sv/sdff_queue.sv -----
module sdff_queue
  import sdff_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  desc_t wdata,
  output logic  full,
  input  logic  rd,
  output desc_t rdata,
  output logic  empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t            slots_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign rdata = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/sdff_back.sv -----
module sdff_back
  import sdff_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  desc_t            q_desc,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [CharW-1:0] out_char,
  output logic             out_last_of_value,
  output logic             out_frame_end
);

  back_state_t         state_r, state_nxt;
  logic                pend_start_r, pend_start_nxt;
  logic                pend_minus_r, pend_minus_nxt;
  logic                closes_r, closes_nxt;
  logic                digits_done_r, digits_done_nxt;
  logic [SampleW-1:0]  mag_r, mag_nxt;
  logic [BcdW-1:0]     bcd_r, bcd_nxt;
  logic [StepW-1:0]    step_r, step_nxt;
  logic [DigIdxW-1:0]  dig_idx_r, dig_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CharW-1:0]    char_r, char_nxt;
  logic                last_r, last_nxt;
  logic                end_r, end_nxt;
  logic                slot_free;
  logic [BcdW-1:0]     bcd_step;
  logic [3:0]          cur_digit;

  assign empty             = ~out_valid_r;
  assign out_char          = char_r;
  assign out_last_of_value = last_r;
  assign out_frame_end     = end_r;

  // The output register can take a new character when it is empty or being read.
  assign slot_free = ~out_valid_r | pop;
  assign bcd_step  = dabble_step(dabble_step(bcd_r, mag_r[SampleW-1]), mag_r[SampleW-2]);
  assign cur_digit = bcd_r[{dig_idx_r, 2'b00} +: 4];

  always_comb begin
    state_nxt       = state_r;
    pend_start_nxt  = pend_start_r;
    pend_minus_nxt  = pend_minus_r;
    closes_nxt      = closes_r;
    digits_done_nxt = digits_done_r;
    mag_nxt         = mag_r;
    bcd_nxt         = bcd_r;
    step_nxt        = step_r;
    dig_idx_nxt     = dig_idx_r;
    out_valid_nxt   = out_valid_r & ~pop;
    char_nxt        = char_r;
    last_nxt        = last_r;
    end_nxt         = end_r;
    q_pop           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop           = 1'b1;
          pend_start_nxt  = q_desc.start;
          pend_minus_nxt  = q_desc.negative;
          closes_nxt      = q_desc.closes;
          digits_done_nxt = 1'b0;
          mag_nxt         = q_desc.mag;
          bcd_nxt         = '0;
          step_nxt        = '0;
          state_nxt       = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt  = bcd_step;
        mag_nxt  = {mag_r[SampleW-BitsPerStep-1:0], {BitsPerStep{1'b0}}};
        step_nxt = step_r + StepW'(1);
        if (step_r == StepW'(ConvSteps - 1)) begin
          dig_idx_nxt = lead_digit(bcd_step);
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b0;
          end_nxt       = 1'b0;
          if (pend_start_r) begin
            char_nxt       = CH_START;
            pend_start_nxt = 1'b0;
          end else if (pend_minus_r) begin
            char_nxt       = CH_MINUS;
            pend_minus_nxt = 1'b0;
          end else if (!digits_done_r) begin
            char_nxt = CH_ZERO + {4'd0, cur_digit};
            if (dig_idx_r == '0) begin
              digits_done_nxt = 1'b1;
            end else begin
              dig_idx_nxt = dig_idx_r - DigIdxW'(1);
            end
          end else begin
            char_nxt  = closes_r ? CH_END : CH_SPACE;
            last_nxt  = 1'b1;
            end_nxt   = closes_r;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_start_r  <= pend_start_nxt;
    pend_minus_r  <= pend_minus_nxt;
    closes_r      <= closes_nxt;
    digits_done_r <= digits_done_nxt;
    mag_r         <= mag_nxt;
    bcd_r         <= bcd_nxt;
    step_r        <= step_nxt;
    dig_idx_r     <= dig_idx_nxt;
    char_r        <= char_nxt;
    last_r        <= last_nxt;
    end_r         <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A descriptor is only taken while the converter is free.
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE) && !q_empty)
    else $error("descriptor taken while busy");

  // Conversion runs its full count of steps before emission starts.
  a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) && (step_r != StepW'(ConvSteps - 1)) |=> (state_r == ST_CONV))
    else $error("conversion left early");

  // A waiting character is held until it is read.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pop |=> out_valid_r && $stable(char_r) && $stable(last_r))
    else $error("output word changed while stalled");

  // The frame end marker only ever rides on the closing separator.
  a_end_on_sep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && end_r |-> last_r && (char_r == CH_END))
    else $error("frame end on a non-separator word");

endmodule

// ----- sv/signed_decimal_frame_formatter.sv -----
// Signed decimal frame formatter. Signed 32-bit words pushed on the input queue
// port come out as an ASCII plotter frame "$v1 v2 ... vn;", one character word
// per pop: '$' opens a frame, a negative value gets '-', digits follow with no
// leading zeros (zero prints as '0', the minimum value as -2147483648), and each
// value ends with a space, or with ';' when it is the last of the frame. The
// separator word carries out_last_of_value, and ';' also carries out_frame_end.
// The frame length lives in the register at byte address 0 of the APB-style
// port (reset 1, zero acts as one); change it only while the block is idle, and
// a new length applies from the next value on. The front classifies a
// word in the cycle it is accepted and parks it in a small descriptor queue
// (QUEUE_DEPTH words), so push keeps being taken while the back end works,
// until the queue fills. The back end takes one descriptor at a time: it
// pops it, runs the binary to decimal converter (two magnitude bits per cycle
// through chained shift-and-add-3 stages), then emits the 2 to 13
// characters, one whenever the output register is free; the output register
// holds a finished character while the next value is converted.
module signed_decimal_frame_formatter
  import sdff_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  in_sample_value,
  output logic                empty,
  input  logic                pop,
  output logic [CharW-1:0]    out_char,
  output logic                out_last_of_value,
  output logic                out_frame_end,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Descriptor traffic between the classifying front and the formatting back.
  desc_t q_wdata;
  desc_t q_rdata;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  // The front tracks the position within the frame and decides, per word,
  // whether it opens a frame, whether it is negative and whether it closes.
  sdff_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .sample_value (in_sample_value),
    .full         (full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_desc       (q_wdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // The queue lets the front accept words while the back end is converting.
  sdff_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The back end converts the magnitude to decimal and sequences characters.
  sdff_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_desc            (q_rdata),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_char          (out_char),
    .out_last_of_value (out_last_of_value),
    .out_frame_end     (out_frame_end)
  );

endmodule

// ----- tb/tb_signed_decimal_frame_formatter.sv -----
`timescale 1ns / 100ps

module tb_signed_decimal_frame_formatter;
  import sdff_pkg::*;

  // Byte addresses on the configuration port. Only the frame length register
  // exists; the word above it is decoded as an unknown register.
  localparam logic [CfgAddrW-1:0] FrameLenAddr = 3'd0;
  localparam logic [CfgAddrW-1:0] UnusedAddr   = 3'd4;

  localparam int Radix        = 10;
  // Settle time that wait_idle adds once every owed character has been read.
  localparam int SettleCycles = 40;
  // The receiver holds off this long during the back-pressure test.
  localparam int HoldCycles   = 300;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HangLimit    = 2000;
  localparam int MaxPrinted   = 50;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
    logic             fend;
  } frame_char_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [SampleW-1:0]  in_sample_value = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [CharW-1:0]    out_char;
  logic                out_last_of_value;
  logic                out_frame_end;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Characters the formatter still owes, oldest first.
  frame_char_t pending_chars[$];

  // Our own copy of the formatter state: the configured frame length and the
  // number of values already printed in the open frame.
  logic [FrameW-1:0] frame_len = 8'd1;
  logic [FrameW-1:0] frame_pos = 8'd0;

  // Traffic shaping: percentage of cycles in which the sender stays idle and
  // the receiver stalls, plus a flag that holds the receiver off entirely.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_pop = 1'b0;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  signed_decimal_frame_formatter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_sample_value  (in_sample_value),
    .empty            (empty),
    .pop              (pop),
    .out_char         (out_char),
    .out_last_of_value(out_last_of_value),
    .out_frame_end    (out_frame_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every mismatch goes through here. Only the first few dozen are printed so
  // that a badly broken build still leaves a readable log.
  task automatic report_mismatch(input string what, input logic [31:0] expected,
                                 input logic [31:0] got);
    if (mismatches < MaxPrinted) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what,
               expected, got);
    end
    mismatches++;
  endtask

  function automatic void add_char(input logic [CharW-1:0] ch, input logic last,
                                   input logic fend);
    frame_char_t c;
    c.ch = ch;
    c.last = last;
    c.fend = fend;
    pending_chars.push_back(c);
  endfunction

  // Works out the characters that one sample adds to the frame and advances
  // the frame position. A frame length of zero closes every value, exactly as
  // a length of one does, and a length lowered below the current position
  // closes the frame on the next value.
  function automatic void format_sample(input logic [SampleW-1:0] raw);
    logic [SampleW-1:0] mag;
    logic [3:0]         digs[MaxDigits];
    int                 n;
    logic               closes;
    mag = raw[SampleW-1] ? (SampleW'(0) - raw) : raw;
    if (frame_pos == 0) begin
      add_char(CH_START, 1'b0, 1'b0);
    end
    if (raw[SampleW-1]) begin
      add_char(CH_MINUS, 1'b0, 1'b0);
    end
    // The minimum value has magnitude 2^31, which still fits unsigned here.
    n = 0;
    do begin
      digs[n] = 4'(mag % Radix);
      mag = mag / Radix;
      n++;
    end while (mag != 0 && n < MaxDigits);
    for (int i = n - 1; i >= 0; i--) begin
      add_char(CH_ZERO + CharW'(digs[i]), 1'b0, 1'b0);
    end
    closes = (9'(frame_pos) + 9'd1) >= 9'(frame_len);
    if (closes) begin
      add_char(CH_END, 1'b1, 1'b1);
      frame_pos = '0;
    end else begin
      add_char(CH_SPACE, 1'b1, 1'b0);
      frame_pos = frame_pos + 8'd1;
    end
  endfunction

  // Random samples spread over digit counts: full-range words, small values,
  // powers of ten and their neighbors, values of a chosen length, and the
  // two ends of the range or zero.
  function automatic logic [SampleW-1:0] random_sample();
    logic [SampleW-1:0] v;
    int unsigned        k;
    int unsigned        p;
    case ($urandom_range(4))
      0: v = $urandom();
      1: v = $urandom_range(99);
      2: begin
        k = $urandom_range(9);
        p = 1;
        repeat (k) p = p * Radix;
        v = p + $urandom_range(2) - 1;
      end
      3: begin
        k = $urandom_range(9, 1);
        p = 1;
        repeat (k - 1) p = p * Radix;
        v = $urandom_range(p * Radix - 1, p);
      end
      default: begin
        case ($urandom_range(2))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          default: v = '0;
        endcase
      end
    endcase
    if ($urandom_range(1)) begin
      v = -v;
    end
    return v;
  endfunction

  // Offers one sample after a random idle gap and waits for the formatter to
  // take it. push stays high afterwards so that words can follow back to back;
  // the next gap or the idle wait lowers it.
  task automatic send_sample(input logic [SampleW-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_sample_value <= v;
    do @(posedge clk); while (full);
    format_sample(v);
  endtask

  // Lets every owed character drain, then gives the back end time to settle
  // so that a register write lands while the formatter is idle.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_register(input logic [CfgAddrW-1:0] addr,
                                input logic [CfgDataW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == FrameLenAddr) begin
      frame_len = data[FrameW-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reads the frame length back and checks it against our copy.
  task automatic check_frame_len();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FrameLenAddr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FrameW-1:0] !== frame_len) begin
      report_mismatch("frame length readback", 32'(frame_len), prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: pops at random unless held off. Decisions are made on the
  // falling edge; hold_pop only changes on rising edges.
  always @(negedge clk) begin
    pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
  end

  // Every character taken from the formatter is compared with the oldest one
  // still owed, field by field.
  always @(posedge clk) begin
    frame_char_t want;
    if (rst_n && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("character with none owed", '0, 32'(out_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch) begin
          report_mismatch("out_char", 32'(want.ch), 32'(out_char));
        end
        if (out_last_of_value !== want.last) begin
          report_mismatch("out_last_of_value", 32'(want.last),
                          32'(out_last_of_value));
        end
        if (out_frame_end !== want.fend) begin
          report_mismatch("out_frame_end", 32'(want.fend), 32'(out_frame_end));
        end
      end
    end
  end

  // Hang detection: any accepted word on any port restarts the count.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HangLimit) begin
        $display("[signed_decimal_frame_formatter] ERROR");
        $finish;
      end
    end
  end

  // One value per frame (the reset length): zero, single digits, the step
  // from nine to ten digits, both ends of the range and the minimum value,
  // whose magnitude has no positive counterpart.
  task automatic test_value_extremes();
    int extremes[] = '{0, 1, -1, 9, 10, -10, 999999999, 1000000000,
                       -1000000000, 2147483647, -2147483647, 32'h8000_0000};
    foreach (extremes[i]) begin
      send_sample(extremes[i]);
    end
    wait_idle();
  endtask

  // A frame of four values followed by the start of another, then a length
  // of zero, which behaves as one. The open frame from the first part is
  // closed by the first value after the change.
  task automatic test_frame_lengths();
    write_register(FrameLenAddr, 32'd4);
    check_frame_len();
    repeat (5) send_sample(random_sample());
    wait_idle();
    write_register(FrameLenAddr, 32'd0);
    check_frame_len();
    repeat (2) send_sample(random_sample());
    wait_idle();
  endtask

  // Three values into a frame of five, then the length drops to two: the
  // next value is already past the new length and must close the frame.
  task automatic test_midframe_shrink();
    write_register(FrameLenAddr, 32'd5);
    repeat (3) send_sample(random_sample());
    wait_idle();
    write_register(FrameLenAddr, 32'd2);
    repeat (2) send_sample(random_sample());
    wait_idle();
  endtask

  // A write to an address with no register behind it must leave the frame
  // length alone.
  task automatic test_unknown_register();
    write_register(FrameLenAddr, 32'd3);
    write_register(UnusedAddr, 32'd1);
    check_frame_len();
    repeat (3) send_sample(random_sample());
    wait_idle();
  endtask

  // Random samples in four traffic phases, each with its own frame length,
  // 255, the largest length the register holds, among them.
  task automatic test_random_traffic();
    int unsigned idle_by_phase[4] = '{0, 84, 0, 7};
    int unsigned stall_by_phase[4] = '{0, 0, 84, 7};
    int unsigned len_by_phase[4];
    len_by_phase = '{3, 255, 1, $urandom_range(12, 2)};
    for (int ph = 0; ph < 4; ph++) begin
      write_register(FrameLenAddr, CfgDataW'(len_by_phase[ph]));
      send_idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      repeat (16) send_sample(random_sample());
      wait_idle();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // The receiver stops popping for a long stretch while the sender keeps
  // offering words at full rate, so the descriptor queue fills and full
  // must hold the input back until popping resumes.
  task automatic test_input_backpressure();
    write_register(FrameLenAddr, 32'd6);
    send_idle_pct = 0;
    stall_pct = 30;
    fork
      begin
        @(posedge clk);
        hold_pop = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_pop = 1'b0;
      end
      repeat (16) send_sample(random_sample());
    join
    wait_idle();
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_value_extremes();
    test_frame_lengths();
    test_midframe_shrink();
    test_unknown_register();
    test_random_traffic();
    test_input_backpressure();

    // Everything has drained in wait_idle; the settle time it adds also
    // catches stray characters produced after the last owed one.
    if (mismatches == 0) begin
      $display("[signed_decimal_frame_formatter] OK");
    end else begin
      $display("[signed_decimal_frame_formatter] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sdff_pkg.sv
sv/sdff_front.sv
sv/sdff_queue.sv
sv/sdff_back.sv
sv/signed_decimal_frame_formatter.sv
tb/tb_signed_decimal_frame_formatter.sv
